/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check across reset failed");

`endif

/* rtl/core/prtt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_pkg
// types, codes and constants of the packet record track table
// ----------------------------------------------------------------------------
package prtt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int END_BACKSTEP        = 50;

   // request operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_END    = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // record life cycle
   typedef enum logic [1:0] {
      ENTRY_FREE  = 2'd0,
      ENTRY_OPEN  = 2'd1,
      ENTRY_ENDED = 2'd2
   } entry_state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] packet_id;
      logic [63:0] now;
      logic [7:0]  end_type;
      logic [7:0]  drop_reason;
      logic [15:0] retransmit_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot_index;
      logic [63:0] start_time;
      logic [8:0]  freed_count;
   } rsp_type;

   // one table slot
   typedef struct packed {
      logic [1:0]  state;
      logic [63:0] id;
      logic [63:0] start;
      logic [63:0] stop;
      logic [7:0]  end_type;
      logic [7:0]  drop_reason;
      logic [15:0] retransmits;
   } record_type;

   // verdict of the compare unit plus the rewritten record
   typedef struct packed {
      logic       hit;
      record_type rec;
   } match_type;

endpackage

/* rtl/core/prtt_record_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_record_mem
// single-port-write, single-port-read record store with registered read data
// ----------------------------------------------------------------------------
module prtt_record_mem #(
   parameter int TABLE_DEPTH = prtt_pkg::TABLE_DEPTH_DEFAULT,
   localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  prtt_pkg::record_type wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output prtt_pkg::record_type rd_data
);
   import prtt_pkg::*;

   record_type mem_ff [TABLE_DEPTH];
   record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/prtt_match_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_match_unit
// shared compare unit: judges one record against the request and builds
// the record to write back
// ----------------------------------------------------------------------------
module prtt_match_unit (
   input  logic [63:0]          lifetime,
   input  prtt_pkg::req_type    req,
   input  prtt_pkg::record_type rec,
   output prtt_pkg::match_type  result
);
   import prtt_pkg::*;

   logic [63:0] age;

   // age wraps modulo 2^64
   assign age = req.now - rec.start;

   always_comb begin
      result.hit = 1'b0;
      result.rec = rec;
      unique case (req.operation)
         OP_INSERT: begin
            result.hit             = (rec.state == ENTRY_FREE);
            result.rec.state       = ENTRY_OPEN;
            result.rec.id          = req.packet_id;
            result.rec.start       = req.now;
            result.rec.retransmits = '0;
         end
         OP_END: begin
            result.hit             = (rec.state == ENTRY_OPEN) && (rec.id == req.packet_id);
            result.rec.state       = ENTRY_ENDED;
            result.rec.stop        = req.now;
            result.rec.end_type    = req.end_type;
            result.rec.drop_reason = req.drop_reason;
            result.rec.retransmits = req.retransmit_count;
         end
         OP_FLUSH: begin
            result.hit       = (rec.state != ENTRY_FREE) && (age > lifetime);
            result.rec.state = ENTRY_FREE;
         end
         default: begin
            result.hit = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/core/packet_record_track_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_record_track_table
// table of packet records with insert, end and aged flush
// ----------------------------------------------------------------------------
// One request at a time. The records sit in a memory with one read and one
// write port; a sequencer walks it one entry per cycle through a shared
// compare unit. Insert and end stop at the first hit; a full table or an end
// miss is found once every entry has been looked at. Flush always visits
// every entry. Code 3 answers without a walk, with an all-zero response.
// The registered entry read port sets the pace of the walk. After reset a
// clearing pass frees every slot; req_ready stays low meanwhile, csr writes
// are taken as ever. A finished response waits in an output register while
// the next request is taken.
// ----------------------------------------------------------------------------
module packet_record_track_table #(
   parameter int TABLE_DEPTH = prtt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  prtt_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output prtt_pkg::rsp_type rsp,
   input  logic              csr_wr_en,
   input  logic [63:0]       csr_wr_data
);
   import prtt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BACKSTEP  = ADDR_W'(END_BACKSTEP);
   localparam logic [ADDR_W-1:0] WRAP_BACK = ADDR_W'(TABLE_DEPTH - END_BACKSTEP);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } seq_state_type;

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] back_addr(input logic [ADDR_W-1:0] a);
      return (a >= BACKSTEP) ? a - BACKSTEP : a + WRAP_BACK;
   endfunction

   function automatic logic [7:0] to_slot(input logic [ADDR_W-1:0] a);
      logic [ADDR_W+7:0] w;
      w = {8'd0, a};
      return w[7:0];
   endfunction

   function automatic logic [8:0] to_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+8:0] w;
      w = {9'd0, c};
      return w[8:0];
   endfunction

   seq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic              data_ok_ff, data_ok_in;
   logic [CNT_W-1:0]  eval_cnt_ff, eval_cnt_in;
   logic [CNT_W-1:0]  freed_ff, freed_in;
   req_type           hold_ff, hold_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [63:0]       lifetime_ff, lifetime_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   record_type        wr_data;
   record_type        rd_data;
   match_type         match;

   prtt_record_mem #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_record_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   prtt_match_unit u_match_unit (
      .lifetime (lifetime_ff),
      .req      (hold_ff),
      .rec      (rd_data),
      .result   (match)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rd_addr_in   = rd_addr_ff;
      cur_addr_in  = cur_addr_ff;
      data_ok_in   = data_ok_ff;
      eval_cnt_in  = eval_cnt_ff;
      freed_in     = freed_ff;
      hold_in      = hold_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      lifetime_in  = lifetime_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_addr_ff;
      wr_data      = match.rec;

      // config register
      if (csr_wr_en) begin
         lifetime_in = csr_wr_data;
      end

      // response drained
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = rd_addr_ff;
            wr_data    = '0;
            rd_addr_in = next_addr(rd_addr_ff);
            if (rd_addr_ff == LAST_ADDR) begin
               rd_addr_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               hold_in     = req;
               data_ok_in  = 1'b0;
               eval_cnt_in = '0;
               freed_in    = '0;
               state_in    = S_SCAN;
               unique case (req.operation)
                  OP_INSERT: begin
                     rd_addr_in = ptr_ff;
                  end
                  OP_END: begin
                     rd_addr_in = back_addr(ptr_ff);
                     ptr_in     = back_addr(ptr_ff);
                  end
                  OP_FLUSH: begin
                     rd_addr_in = '0;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr_in  = next_addr(rd_addr_ff);
            cur_addr_in = rd_addr_ff;
            data_ok_in  = 1'b1;
            if (data_ok_ff) begin
               eval_cnt_in = eval_cnt_ff + 1'b1;
               if (hold_ff.operation == OP_FLUSH) begin
                  // flush frees every aged record in one sweep
                  if (match.hit) begin
                     wr_en    = 1'b1;
                     freed_in = freed_ff + 1'b1;
                  end
                  if (eval_cnt_ff == LAST_CNT) begin
                     res_in             = '0;
                     res_in.status      = ST_DONE;
                     res_in.freed_count = to_count(freed_in);
                     state_in           = S_FINISH;
                  end
               end else if (match.hit) begin
                  // first hit opens or closes the slot
                  wr_en              = 1'b1;
                  res_in             = '0;
                  res_in.status      = ST_DONE;
                  res_in.slot_index  = to_slot(cur_addr_ff);
                  res_in.start_time  = match.rec.start;
                  ptr_in             = next_addr(cur_addr_ff);
                  state_in           = S_FINISH;
               end else if (eval_cnt_ff == LAST_CNT) begin
                  // whole table seen without a hit
                  res_in        = '0;
                  res_in.status = (hold_ff.operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  state_in      = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         rd_addr_ff   <= '0;
         data_ok_ff   <= 1'b0;
         eval_cnt_ff  <= '0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lifetime_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_addr_ff   <= rd_addr_in;
         data_ok_ff   <= data_ok_in;
         eval_cnt_ff  <= eval_cnt_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
         lifetime_ff  <= lifetime_in;
      end
      cur_addr_ff <= cur_addr_in;
      hold_ff     <= hold_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

endmodule

/* rtl/core/prtt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_checker
// port-level checks of the packet record track table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prtt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input prtt_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input prtt_pkg::rsp_type rsp
);
   import prtt_pkg::*;

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

   // one request at a time
   `ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && req_ready, !req_ready)

   // clearing pass keeps the request side closed
   `ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_ready)

   // failed insert or end carries no slot, time or count
   `ASSERT_IMPLY(a_fail_fields_zero, clock, reset, rsp_valid && rsp.status != ST_DONE, rsp.slot_index == '0 && rsp.start_time == '0 && rsp.freed_count == '0)

   // a freed count only comes from flush
   `ASSERT_IMPLY(a_freed_only_flush, clock, reset, rsp_valid && rsp.freed_count != '0, rsp.status == ST_DONE && rsp.slot_index == '0 && rsp.start_time == '0)

endmodule

bind packet_record_track_table prtt_checker u_prtt_checker (.*);
